[rtl/battery_cell_extremum_tracker_defines.svh]
// Assertion macros for the battery cell extremum tracker.
`ifndef BATTERY_CELL_EXTREMUM_TRACKER_DEFINES_SVH
`define BATTERY_CELL_EXTREMUM_TRACKER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BCET_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define BCET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BCET_ASSERT(lbl, cond, msg)
`define BCET_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/bcet_pkg.sv]
// Shared types and constants for the battery cell extremum tracker.
package bcet_pkg;

  localparam int BCET_MAX_PACKS     = 64;
  localparam int BCET_MAX_CELLS     = 1024;

  localparam int PACK_OUT_W = 7;
  localparam int CELL_OUT_W = 11;

  localparam logic KIND_VOLT = 1'b0;
  localparam logic KIND_TEMP = 1'b1;

  localparam logic [15:0] VOLT_BAD_A = 16'hFFFF;
  localparam logic [15:0] VOLT_BAD_B = 16'hFFFE;
  localparam logic [15:0] VOLT_RESET = 16'hFFFE;

  typedef struct packed {
    logic        sample_kind;
    logic [15:0] sample_value;
    logic        new_pack;
    logic        scan_end;
  } in_req_t;

  typedef struct packed {
    logic        [15:0]           high_volt;
    logic        [PACK_OUT_W-1:0] high_volt_pack;
    logic        [CELL_OUT_W-1:0] high_volt_cell;
    logic        [15:0]           low_volt;
    logic        [PACK_OUT_W-1:0] low_volt_pack;
    logic        [CELL_OUT_W-1:0] low_volt_cell;
    logic signed [15:0]           high_temp;
    logic        [PACK_OUT_W-1:0] high_temp_pack;
    logic        [CELL_OUT_W-1:0] high_temp_cell;
    logic signed [15:0]           low_temp;
    logic        [PACK_OUT_W-1:0] low_temp_pack;
    logic        [CELL_OUT_W-1:0] low_temp_cell;
  } out_req_t;

  typedef struct packed {
    logic full;
    logic drain;
  } out_stat_t;

endpackage

[rtl/bcet_in_stage.sv]
// Input register stage with hold when the result register cannot take a scan end.
`include "battery_cell_extremum_tracker_defines.svh"
module bcet_in_stage
  import bcet_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_req_t   in_req,
  input  out_stat_t out_stat,
  output in_req_t   item,
  output logic      go
);

  logic    valid_r, valid_nxt;
  in_req_t item_r;
  logic    accept;

  assign go       = valid_r && (!item_r.scan_end || !out_stat.full || out_stat.drain);
  assign in_stall = valid_r && !go;
  assign accept   = in_valid && !in_stall;
  assign item     = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (go) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_req;
    end
  end

  `BCET_ASSERT(a_go_needs_item, !go || valid_r, "go without a held item")
  `BCET_ASSERT_NEXT(a_held_item_stays, valid_r && !go, valid_r && $stable(item_r), "held item lost")

endmodule

[rtl/bcet_track.sv]
// Pack and cell counters plus the four running extremes with their positions.
`include "battery_cell_extremum_tracker_defines.svh"
module bcet_track
  import bcet_pkg::*;
#(
  parameter int MAX_PACKS          = BCET_MAX_PACKS,
  parameter int MAX_CELLS_PER_PACK = BCET_MAX_CELLS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     go,
  input  in_req_t  item,
  output logic     res_load,
  output out_req_t res
);

  localparam int PW = $clog2(MAX_PACKS + 1);
  localparam int CW = $clog2(MAX_CELLS_PER_PACK + 1);
  localparam logic [PW-1:0] PACK_MAX = PW'(MAX_PACKS);
  localparam logic [CW-1:0] CELL_MAX = CW'(MAX_CELLS_PER_PACK);

  localparam int SLOT_HV = 0;
  localparam int SLOT_LV = 1;
  localparam int SLOT_HT = 2;
  localparam int SLOT_LT = 3;

  logic        [PW-1:0] pack_r, pack_nxt;
  logic        [CW-1:0] vcnt_r, vcnt_nxt;
  logic        [CW-1:0] tcnt_r, tcnt_nxt;
  logic                 vseed_r, vseed_nxt;
  logic                 tseed_r, tseed_nxt;
  logic        [15:0]   vhi_r, vhi_nxt, vlo_r, vlo_nxt;
  logic signed [15:0]   thi_r, thi_nxt, tlo_r, tlo_nxt;
  logic        [PW-1:0] xpack_r [4];
  logic        [PW-1:0] xpack_nxt [4];
  logic        [CW-1:0] xcell_r [4];
  logic        [CW-1:0] xcell_nxt [4];
  logic signed [15:0]   tval;
  logic                 vbad;

  assign tval = $signed(item.sample_value);
  assign vbad = (item.sample_value == VOLT_BAD_A) || (item.sample_value == VOLT_BAD_B);

  always_comb begin
    pack_nxt  = pack_r;
    vcnt_nxt  = vcnt_r;
    tcnt_nxt  = tcnt_r;
    vseed_nxt = vseed_r;
    tseed_nxt = tseed_r;
    vhi_nxt   = vhi_r;
    vlo_nxt   = vlo_r;
    thi_nxt   = thi_r;
    tlo_nxt   = tlo_r;
    xpack_nxt = xpack_r;
    xcell_nxt = xcell_r;

    if (pack_r == '0) begin
      pack_nxt = PW'(1);
      vcnt_nxt = '0;
      tcnt_nxt = '0;
    end else if (item.new_pack) begin
      if (pack_r < PACK_MAX) begin
        pack_nxt = pack_r + PW'(1);
      end
      vcnt_nxt = '0;
      tcnt_nxt = '0;
    end

    if (item.sample_kind == KIND_VOLT) begin
      if (vcnt_nxt < CELL_MAX) begin
        vcnt_nxt = vcnt_nxt + CW'(1);
      end
      if (!vseed_r) begin
        vseed_nxt = 1'b1;
        vhi_nxt   = item.sample_value;
        vlo_nxt   = item.sample_value;
        xpack_nxt[SLOT_HV] = PW'(1);
        xcell_nxt[SLOT_HV] = CW'(1);
        xpack_nxt[SLOT_LV] = PW'(1);
        xcell_nxt[SLOT_LV] = CW'(1);
      end else if (!vbad) begin
        if (item.sample_value > vhi_r) begin
          vhi_nxt = item.sample_value;
          xpack_nxt[SLOT_HV] = pack_nxt;
          xcell_nxt[SLOT_HV] = vcnt_nxt;
        end
        if (item.sample_value < vlo_r) begin
          vlo_nxt = item.sample_value;
          xpack_nxt[SLOT_LV] = pack_nxt;
          xcell_nxt[SLOT_LV] = vcnt_nxt;
        end
      end
    end else begin
      if (tcnt_nxt < CELL_MAX) begin
        tcnt_nxt = tcnt_nxt + CW'(1);
      end
      if (!tseed_r) begin
        tseed_nxt = 1'b1;
        thi_nxt   = tval;
        tlo_nxt   = tval;
        xpack_nxt[SLOT_HT] = PW'(1);
        xcell_nxt[SLOT_HT] = CW'(1);
        xpack_nxt[SLOT_LT] = PW'(1);
        xcell_nxt[SLOT_LT] = CW'(1);
      end else begin
        if (tval > thi_r) begin
          thi_nxt = tval;
          xpack_nxt[SLOT_HT] = pack_nxt;
          xcell_nxt[SLOT_HT] = tcnt_nxt;
        end
        if (tval < tlo_r) begin
          tlo_nxt = tval;
          xpack_nxt[SLOT_LT] = pack_nxt;
          xcell_nxt[SLOT_LT] = tcnt_nxt;
        end
      end
    end
  end

  assign res_load = go && item.scan_end;

  always_comb begin
    res.high_volt      = vhi_nxt;
    res.high_volt_pack = PACK_OUT_W'(xpack_nxt[SLOT_HV]);
    res.high_volt_cell = CELL_OUT_W'(xcell_nxt[SLOT_HV]);
    res.low_volt       = vlo_nxt;
    res.low_volt_pack  = PACK_OUT_W'(xpack_nxt[SLOT_LV]);
    res.low_volt_cell  = CELL_OUT_W'(xcell_nxt[SLOT_LV]);
    res.high_temp      = thi_nxt;
    res.high_temp_pack = PACK_OUT_W'(xpack_nxt[SLOT_HT]);
    res.high_temp_cell = CELL_OUT_W'(xcell_nxt[SLOT_HT]);
    res.low_temp       = tlo_nxt;
    res.low_temp_pack  = PACK_OUT_W'(xpack_nxt[SLOT_LT]);
    res.low_temp_cell  = CELL_OUT_W'(xcell_nxt[SLOT_LT]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || res_load) begin
      pack_r  <= '0;
      vcnt_r  <= '0;
      tcnt_r  <= '0;
      vseed_r <= 1'b0;
      tseed_r <= 1'b0;
      vhi_r   <= VOLT_RESET;
      vlo_r   <= VOLT_RESET;
      thi_r   <= '0;
      tlo_r   <= '0;
      for (int i = 0; i < 4; i++) begin
        xpack_r[i] <= PW'(1);
        xcell_r[i] <= CW'(1);
      end
    end else if (go) begin
      pack_r  <= pack_nxt;
      vcnt_r  <= vcnt_nxt;
      tcnt_r  <= tcnt_nxt;
      vseed_r <= vseed_nxt;
      tseed_r <= tseed_nxt;
      vhi_r   <= vhi_nxt;
      vlo_r   <= vlo_nxt;
      thi_r   <= thi_nxt;
      tlo_r   <= tlo_nxt;
      xpack_r <= xpack_nxt;
      xcell_r <= xcell_nxt;
    end
  end

  `BCET_ASSERT(a_pack_bound, pack_r <= PACK_MAX, "pack count past limit")
  `BCET_ASSERT(a_cell_bound, (vcnt_r <= CELL_MAX) && (tcnt_r <= CELL_MAX), "cell count past limit")
  `BCET_ASSERT_NEXT(a_rearm, res_load, (pack_r == '0) && !vseed_r && !tseed_r, "no rearm after scan end")

endmodule

[rtl/bcet_out_stage.sv]
// Result register toward the output channel.
`include "battery_cell_extremum_tracker_defines.svh"
module bcet_out_stage
  import bcet_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_load,
  input  out_req_t  res,
  output logic      out_valid,
  input  logic      out_stall,
  output out_req_t  out_req,
  output out_stat_t out_stat
);

  logic     valid_r, valid_nxt;
  out_req_t req_r;

  assign out_valid      = valid_r;
  assign out_req        = req_r;
  assign out_stat.full  = valid_r;
  assign out_stat.drain = valid_r && !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (res_load) begin
      valid_nxt = 1'b1;
    end else if (out_stat.drain) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      req_r <= res;
    end
  end

  `BCET_ASSERT(a_no_overwrite, !(res_load && valid_r && out_stall), "result overwritten")

endmodule

[rtl/battery_cell_extremum_tracker.sv]
// Top level of the battery cell extremum tracker.
// A scan-end request passes the input register, then the result register that drives out_valid.
// Throughput: one request per cycle; the only hold is a scan end meeting a stalled full result.
// The per-request update of counters and the four extremes is one compare layer.
// Reset (rst_n low, synchronous) clears counters, seeds, both valid flags; presets extremes.
module battery_cell_extremum_tracker
  import bcet_pkg::*;
#(
  parameter int MAX_PACKS          = BCET_MAX_PACKS,
  parameter int MAX_CELLS_PER_PACK = BCET_MAX_CELLS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_req
);

  in_req_t   item;
  logic      go;
  logic      res_load;
  out_req_t  res;
  out_stat_t out_stat;

  bcet_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_stat (out_stat),
    .item     (item),
    .go       (go)
  );

  bcet_track #(
    .MAX_PACKS          (MAX_PACKS),
    .MAX_CELLS_PER_PACK (MAX_CELLS_PER_PACK)
  ) u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .item     (item),
    .res_load (res_load),
    .res      (res)
  );

  bcet_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req),
    .out_stat  (out_stat)
  );

endmodule
